@@ design/awu_pkg.sv @@
`timescale 1ns / 1ps
package awu_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_BITS  = 24;
   localparam int IDX_W      = 12;
   localparam int LR_W       = 25;
   localparam int MS1_W      = 20;
   localparam int MS2_W      = 26;
   localparam int CSR_DATA_W = 26;
   localparam int CSR_IDX_W  = 2;
   localparam int ACC_W      = 64;
   localparam int G2_W       = 39;
   localparam int MHAT_W     = 52;
   localparam int RAD_W      = 58;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int NUM_W      = MHAT_W + 5;
   localparam int HI_W       = NUM_W - FRAC_BITS;
   localparam int PHI_W      = LR_W + HI_W;
   localparam int PLO_W      = LR_W + FRAC_BITS + 1;
   localparam int STEP_W     = PHI_W + 1;
   localparam int WIDE_W     = STEP_W + 2;

   localparam int DEFAULT_NUM_ELEMENTS = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_MOMENT_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_MOMENT_SCALE = 2'd2;

   localparam logic [LR_W-1:0]  LR_RESET  = 25'd16777;
   localparam logic [MS1_W-1:0] MS1_RESET = 20'd655360;
   localparam logic [MS2_W-1:0] MS2_RESET = 26'd65536000;

   localparam logic [31:0] BETA1           = 32'd3865470566;
   localparam logic [31:0] ONE_MINUS_BETA1 = 32'd429496730;
   localparam logic [31:0] BETA2           = 32'd4290672329;
   localparam logic [31:0] ONE_MINUS_BETA2 = 32'd4294967;
   localparam logic [ACC_W-1:0] ROUND_Q32  = 64'h0000_0000_8000_0000;
   localparam logic [RAD_W-1:0] EPS_Q40    = 58'd65536;
   localparam logic [DATA_W-1:0] V_MAX     = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] W_MAX     = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] W_MIN     = 32'h8000_0000;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   typedef struct packed {
      logic [IDX_W-1:0]         element_index;
      logic signed [DATA_W-1:0] grad_value;
      logic signed [DATA_W-1:0] weight_value;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]         element_index_out;
      logic signed [DATA_W-1:0] new_weight;
   } rsp_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]  element_index;
      logic [DATA_W-1:0] weight;
      logic              m_negative;
      logic [MHAT_W-1:0] mhat;
   } root_tag_type;

   typedef struct packed {
      logic [IDX_W-1:0]  element_index;
      logic [DATA_W-1:0] weight;
      logic              m_negative;
   } div_tag_type;

endpackage

@@ design/adam_weight_update.sv @@
`timescale 1ns / 1ps
// Adam weight update: takes one transaction per cycle, each carrying an element index,
// its gradient and its current weight, while neither the clear after reset nor a stalled
// result side holds it off, and returns one transaction per input with the echoed index
// and the saturated new weight, in order. The moment stores are synchronous-read memories
// updated by a read-modify-write with forwarding, so repeated indices in consecutive
// transactions are handled at full rate. Most of the pipeline depth lies in the 29-stage
// square root and the 57-stage divider. After reset the block clears both stores, one
// entry per cycle, and accepts no transaction until the clear is done; configuration writes
// are taken at any time but must only be issued while the block is idle.
module adam_weight_update
   import awu_pkg::*;
#(
   parameter int NUM_ELEMENTS = DEFAULT_NUM_ELEMENTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int AW = addr_width(NUM_ELEMENTS);

   logic [LR_W-1:0]  lr_ff;
   logic [MS1_W-1:0] fms_ff;
   logic [MS2_W-1:0] sms_ff;

   logic adv, busy, accept;

   logic [DATA_W-1:0] g_bits, ag, g_off;
   logic [ACC_W-1:0]  sq_in, g1_in;

   logic              s0_valid_ff;
   logic [IDX_W-1:0]  s0_idx_ff;
   logic [DATA_W-1:0] s0_w_ff;
   logic [ACC_W-1:0]  s0_sq_ff, s0_g1_ff;
   logic [ACC_W-1:0]  sq_round, g2_term;
   logic [G2_W-1:0]   g2;
   logic [AW-1:0]     slot;

   logic [IDX_W-1:0]  s1_idx_ff, s2_idx_ff;
   logic [DATA_W-1:0] s1_w_ff, s2_w_ff;

   logic              mo_valid;
   logic [DATA_W-1:0] mo_m, mo_v, m_mag;

   logic              s3_valid_ff;
   logic [RAD_W-1:0]  s3_rad_ff;
   root_tag_type      s3_tag_ff, s3_tag_in;

   logic              rt_valid;
   logic [ROOT_W-1:0] rt_root;
   root_tag_type      rt_tag;

   logic              d0_valid_ff;
   logic [NUM_W-1:0]  d0_num_ff;
   logic [ROOT_W-1:0] d0_den_ff;
   div_tag_type       d0_tag_ff, d0_tag_in;

   logic              dv_valid;
   logic [NUM_W-1:0]  dv_quo;
   div_tag_type       dv_tag;

   logic              p_valid_ff;
   logic [PHI_W-1:0]  p_hi_ff;
   logic [PLO_W-1:0]  p_lo_ff;
   div_tag_type       p_tag_ff;

   logic              t_valid_ff;
   logic [STEP_W-1:0] t_step_ff;
   div_tag_type       t_tag_ff;

   logic [WIDE_W-1:0] w_wide, step_wide, nw;
   logic [DATA_W-1:0] nw_sat;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = busy || !adv;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= LR_RESET;
         fms_ff <= MS1_RESET;
         sms_ff <= MS2_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEARNING_RATE: begin
               lr_ff <= csr_wr_data[LR_W-1:0];
            end
            CSR_FIRST_MOMENT_SCALE: begin
               fms_ff <= csr_wr_data[MS1_W-1:0];
            end
            CSR_SECOND_MOMENT_SCALE: begin
               sms_ff <= csr_wr_data[MS2_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      g_bits = req_payload.grad_value;
      ag     = g_bits[DATA_W-1] ? (~g_bits + 1'b1) : g_bits;
      g_off  = {~g_bits[DATA_W-1], g_bits[DATA_W-2:0]};
      sq_in  = ACC_W'(ag) * ACC_W'(ag);
      g1_in  = ACC_W'(ONE_MINUS_BETA1) * ACC_W'(g_off);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_idx_ff <= req_payload.element_index;
         s0_w_ff   <= req_payload.weight_value;
         s0_sq_ff  <= sq_in;
         s0_g1_ff  <= g1_in;
      end
   end

   if (NUM_ELEMENTS >= (1 << IDX_W)) begin : g_direct
      assign slot = AW'(s0_idx_ff);
   end else begin : g_mod
      localparam int RECIP_SH = 40;
      localparam logic [RECIP_SH:0] MOD_RECIP =
         (RECIP_SH + 1)'(((64'd1 << RECIP_SH) + 64'(NUM_ELEMENTS) - 64'd1)
         / 64'(NUM_ELEMENTS));
      localparam int PROD_W = IDX_W + RECIP_SH + 1;
      logic [PROD_W-1:0] quo_prod;
      logic [IDX_W-1:0]  quo_ff;
      logic [IDX_W-1:0]  rem;

      assign quo_prod = PROD_W'(req_payload.element_index) * PROD_W'(MOD_RECIP);
      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff <= quo_prod[RECIP_SH+IDX_W-1:RECIP_SH];
         end
      end
      assign rem  = s0_idx_ff - IDX_W'(quo_ff * IDX_W'(NUM_ELEMENTS));
      assign slot = AW'(rem);
   end

   always_comb begin
      sq_round = s0_sq_ff + ACC_W'(1 << (FRAC_BITS - 1));
      g2       = sq_round[FRAC_BITS+G2_W-1:FRAC_BITS];
      g2_term  = ACC_W'(ONE_MINUS_BETA2) * ACC_W'(g2);
   end

   awu_moment #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_moment (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s0_valid_ff),
      .in_slot   (slot),
      .in_g1_term(s0_g1_ff),
      .in_g2_term(g2_term),
      .busy      (busy),
      .out_valid (mo_valid),
      .out_m     (mo_m),
      .out_v     (mo_v)
   );

   always_comb begin
      m_mag                   = mo_m[DATA_W-1] ? (~mo_m + 1'b1) : mo_m;
      s3_tag_in.element_index = s2_idx_ff;
      s3_tag_in.weight        = s2_w_ff;
      s3_tag_in.m_negative    = mo_m[DATA_W-1];
      s3_tag_in.mhat          = MHAT_W'(m_mag) * MHAT_W'(fms_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= mo_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff <= s0_idx_ff;
         s1_w_ff   <= s0_w_ff;
         s2_idx_ff <= s1_idx_ff;
         s2_w_ff   <= s1_w_ff;
         s3_rad_ff <= RAD_W'(mo_v) * RAD_W'(sms_ff) + EPS_Q40;
         s3_tag_ff <= s3_tag_in;
      end
   end

   awu_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (s3_valid_ff),
      .in_radicand(s3_rad_ff),
      .in_tag     (s3_tag_ff),
      .out_valid  (rt_valid),
      .out_root   (rt_root),
      .out_tag    (rt_tag)
   );

   always_comb begin
      d0_tag_in.element_index = rt_tag.element_index;
      d0_tag_in.weight        = rt_tag.weight;
      d0_tag_in.m_negative    = rt_tag.m_negative;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d0_valid_ff <= 1'b0;
      end else if (adv) begin
         d0_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d0_num_ff <= NUM_W'({rt_tag.mhat, 4'b0000}) + NUM_W'(rt_root >> 1);
         d0_den_ff <= rt_root;
         d0_tag_ff <= d0_tag_in;
      end
   end

   awu_div u_div (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (d0_valid_ff),
      .in_numerator(d0_num_ff),
      .in_divisor  (d0_den_ff),
      .in_tag      (d0_tag_ff),
      .out_valid   (dv_valid),
      .out_quotient(dv_quo),
      .out_tag     (dv_tag)
   );

   always_comb begin
      w_wide    = WIDE_W'($signed(t_tag_ff.weight));
      step_wide = WIDE_W'(t_step_ff);
      nw        = t_tag_ff.m_negative ? (w_wide + step_wide) : (w_wide - step_wide);
      if (nw[WIDE_W-1:DATA_W-1] == '0 || nw[WIDE_W-1:DATA_W-1] == '1) begin
         nw_sat = nw[DATA_W-1:0];
      end else if (nw[WIDE_W-1]) begin
         nw_sat = W_MIN;
      end else begin
         nw_sat = W_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         t_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff   <= dv_valid;
         t_valid_ff   <= p_valid_ff;
         rsp_valid_ff <= t_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_hi_ff   <= PHI_W'(lr_ff) * PHI_W'(dv_quo[NUM_W-1:FRAC_BITS]);
         p_lo_ff   <= PLO_W'(lr_ff) * PLO_W'(dv_quo[FRAC_BITS-1:0])
                      + PLO_W'(1 << (FRAC_BITS - 1));
         p_tag_ff  <= dv_tag;
         t_step_ff <= STEP_W'(p_hi_ff) + STEP_W'(p_lo_ff[PLO_W-1:FRAC_BITS]);
         t_tag_ff  <= p_tag_ff;
         rsp_payload_ff.element_index_out <= t_tag_ff.element_index;
         rsp_payload_ff.new_weight        <= nw_sat;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ design/awu_ram.sv @@
`timescale 1ns / 1ps
module awu_ram
   import awu_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = DEFAULT_NUM_ELEMENTS
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [addr_width(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]             wr_data,
   input  logic                         rd_en,
   input  logic [addr_width(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/awu_moment.sv @@
`timescale 1ns / 1ps
module awu_moment
   import awu_pkg::*;
#(
   parameter int NUM_ELEMENTS = DEFAULT_NUM_ELEMENTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [addr_width(NUM_ELEMENTS)-1:0] in_slot,
   input  logic [ACC_W-1:0]                    in_g1_term,
   input  logic [ACC_W-1:0]                    in_g2_term,
   output logic                                busy,
   output logic                                out_valid,
   output logic [DATA_W-1:0]                   out_m,
   output logic [DATA_W-1:0]                   out_v
);

   localparam int AW = addr_width(NUM_ELEMENTS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ELEMENTS - 1);

   logic              clr_ff, clr_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              s1_valid_ff;
   logic [AW-1:0]     s1_slot_ff;
   logic [ACC_W-1:0]  s1_g1_ff, s1_g2_ff;
   logic              s2_valid_ff;
   logic [AW-1:0]     s2_slot_ff;
   logic [DATA_W-1:0] s2_m_ff, s2_v_ff;

   logic              fwd, wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] m_rd, v_rd, m_old, v_old, m_off, m_new, v_new, m_wr, v_wr;
   logic [ACC_W-1:0]  m_acc, v_acc;

   always_comb begin
      fwd   = s2_valid_ff && (s2_slot_ff == s1_slot_ff);
      m_old = fwd ? s2_m_ff : m_rd;
      v_old = fwd ? s2_v_ff : v_rd;
      m_off = {~m_old[DATA_W-1], m_old[DATA_W-2:0]};
      m_acc = ACC_W'(BETA1) * ACC_W'(m_off) + s1_g1_ff + ROUND_Q32;
      m_new = {~m_acc[ACC_W-1], m_acc[ACC_W-2:ACC_W-DATA_W]};
      v_acc = ACC_W'(BETA2) * ACC_W'(v_old) + s1_g2_ff + ROUND_Q32;
      v_new = v_acc[ACC_W-1] ? V_MAX : v_acc[ACC_W-1:ACC_W-DATA_W];
      wr_en   = clr_ff || (s1_valid_ff && adv);
      wr_addr = clr_ff ? clr_addr_ff : s1_slot_ff;
      m_wr    = clr_ff ? '0 : m_new;
      v_wr    = clr_ff ? '0 : v_new;
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   awu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_ELEMENTS)) m_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(m_wr),
      .rd_en  (adv),
      .rd_addr(in_slot),
      .rd_data(m_rd)
   );

   awu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_ELEMENTS)) v_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(v_wr),
      .rd_en  (adv),
      .rd_addr(in_slot),
      .rd_data(v_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         if (adv) begin
            s1_valid_ff <= in_valid;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_slot_ff <= in_slot;
         s1_g1_ff   <= in_g1_term;
         s1_g2_ff   <= in_g2_term;
         s2_slot_ff <= s1_slot_ff;
         s2_m_ff    <= m_new;
         s2_v_ff    <= v_new;
      end
   end

   assign busy      = clr_ff;
   assign out_valid = s2_valid_ff;
   assign out_m     = s2_m_ff;
   assign out_v     = s2_v_ff;

endmodule

@@ design/awu_sqrt.sv @@
`timescale 1ns / 1ps
module awu_sqrt
   import awu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_radicand,
   input  root_tag_type      in_tag,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output root_tag_type      out_tag
);

   localparam int RW = ROOT_W + 2;

   logic              valid_ff [ROOT_W];
   logic [RW-1:0]     rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [ROOT_W];
   root_tag_type      tag_ff   [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              valid_p;
      logic [RW-1:0]     rem_p, rem_sh, trial, rem_in;
      logic [ROOT_W-1:0] root_p, root_in;
      logic [RAD_W-1:0]  rad_p;
      root_tag_type      tag_p;

      if (k == 0) begin : g_first
         assign valid_p = in_valid;
         assign rem_p   = '0;
         assign root_p  = '0;
         assign rad_p   = in_radicand;
         assign tag_p   = in_tag;
      end else begin : g_next
         assign valid_p = valid_ff[k-1];
         assign rem_p   = rem_ff[k-1];
         assign root_p  = root_ff[k-1];
         assign rad_p   = rad_ff[k-1];
         assign tag_p   = tag_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_p[RW-3:0], rad_p[RAD_W-1:RAD_W-2]};
         trial  = {root_p, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_p[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_p[RAD_W-3:0], 2'b00};
            tag_ff[k]  <= tag_p;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

@@ design/awu_div.sv @@
`timescale 1ns / 1ps
module awu_div
   import awu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_numerator,
   input  logic [ROOT_W-1:0] in_divisor,
   input  div_tag_type       in_tag,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quotient,
   output div_tag_type       out_tag
);

   localparam int DW = ROOT_W + 1;

   logic              valid_ff [NUM_W];
   logic [DW-1:0]     rem_ff   [NUM_W];
   logic [NUM_W-1:0]  num_ff   [NUM_W];
   logic [NUM_W-1:0]  quo_ff   [NUM_W];
   logic [ROOT_W-1:0] den_ff   [NUM_W];
   div_tag_type       tag_ff   [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              valid_p, qbit;
      logic [DW-1:0]     rem_p, rem_sh, rem_in;
      logic [NUM_W-1:0]  num_p, quo_p;
      logic [ROOT_W-1:0] den_p;
      div_tag_type       tag_p;

      if (k == 0) begin : g_first
         assign valid_p = in_valid;
         assign rem_p   = '0;
         assign num_p   = in_numerator;
         assign quo_p   = '0;
         assign den_p   = in_divisor;
         assign tag_p   = in_tag;
      end else begin : g_next
         assign valid_p = valid_ff[k-1];
         assign rem_p   = rem_ff[k-1];
         assign num_p   = num_ff[k-1];
         assign quo_p   = quo_ff[k-1];
         assign den_p   = den_ff[k-1];
         assign tag_p   = tag_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_p[DW-2:0], num_p[NUM_W-1]};
         qbit   = (rem_sh >= {1'b0, den_p});
         rem_in = qbit ? (rem_sh - {1'b0, den_p}) : rem_sh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= {num_p[NUM_W-2:0], 1'b0};
            quo_ff[k] <= {quo_p[NUM_W-2:0], qbit};
            den_ff[k] <= den_p;
            tag_ff[k] <= tag_p;
         end
      end
   end

   assign out_valid    = valid_ff[NUM_W-1];
   assign out_quotient = quo_ff[NUM_W-1];
   assign out_tag      = tag_ff[NUM_W-1];

endmodule

@@ test/awu_scoreboard.sv @@
`timescale 1ns / 1ps
module awu_scoreboard
   import awu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    error_count,
   output int                    weights_pending
);

   localparam longint HALF = 64'sd2147483648;

   logic [LR_W-1:0]          lr_reg;
   logic [MS1_W-1:0]         ms1_reg;
   logic [MS2_W-1:0]         ms2_reg;
   logic signed [DATA_W-1:0] m_store [DEFAULT_NUM_ELEMENTS];
   logic [DATA_W-1:0]        v_store [DEFAULT_NUM_ELEMENTS];
   rsp_payload_type          weight_queue [$];

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic rsp_payload_type updated_weight(input req_payload_type p);
      rsp_payload_type res;
      int slot;
      longint g, w, m_old, m_new, nw;
      longint unsigned acc, ag, g2, v_new, m_mag, mhat, vhat, den, ratio, hi, lo, step;
      slot = p.element_index;
      g = longint'(p.grad_value);
      w = longint'(p.weight_value);
      m_old = longint'(m_store[slot]);
      acc = 64'(BETA1) * longint'(m_old + HALF) + 64'(ONE_MINUS_BETA1) * longint'(g + HALF)
         + (64'd1 << 31);
      m_new = longint'(acc >> 32) - HALF;
      ag = (g < 0) ? -g : g;
      g2 = (ag * ag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      acc = 64'(BETA2) * 64'(v_store[slot]) + 64'(ONE_MINUS_BETA2) * g2 + (64'd1 << 31);
      v_new = acc >> 32;
      if (v_new > 64'h7FFF_FFFF) v_new = 64'h7FFF_FFFF;
      m_store[slot] = m_new[DATA_W-1:0];
      v_store[slot] = v_new[DATA_W-1:0];
      m_mag = (m_new < 0) ? -m_new : m_new;
      mhat = m_mag * 64'(ms1_reg);
      vhat = v_new * 64'(ms2_reg) + 64'd65536;
      den = floor_sqrt(vhat);
      if (den == 0) den = 1;
      ratio = ((mhat << 4) + (den >> 1)) / den;
      hi = ratio >> FRAC_BITS;
      lo = ratio & ((64'd1 << FRAC_BITS) - 1);
      step = 64'(lr_reg) * hi + ((64'(lr_reg) * lo + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      nw = (m_new < 0) ? w + longint'(step) : w - longint'(step);
      if (nw > HALF - 1) nw = HALF - 1;
      if (nw < -HALF) nw = -HALF;
      res.element_index_out = p.element_index;
      res.new_weight = nw[DATA_W-1:0];
      return res;
   endfunction

   assign weights_pending = weight_queue.size();

   always @(posedge clock) begin
      rsp_payload_type exp_w;
      if (reset) begin
         lr_reg <= LR_RESET;
         ms1_reg <= MS1_RESET;
         ms2_reg <= MS2_RESET;
         for (int i = 0; i < DEFAULT_NUM_ELEMENTS; i++) begin
            m_store[i] = '0;
            v_store[i] = '0;
         end
         weight_queue.delete();
         error_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (weight_queue.size() == 0) begin
               if (error_count < 10)
                  $display("Unexpected transaction: index %0d weight %h",
                     rsp_payload.element_index_out, rsp_payload.new_weight);
               error_count <= error_count + 1;
            end else begin
               exp_w = weight_queue.pop_front();
               if (exp_w !== rsp_payload) begin
                  if (error_count < 10)
                     $display("Mismatch: expected index %0d weight %h, got index %0d weight %h",
                        exp_w.element_index_out, exp_w.new_weight,
                        rsp_payload.element_index_out, rsp_payload.new_weight);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) weight_queue.push_back(updated_weight(req_payload));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LEARNING_RATE: begin
                  lr_reg <= csr_wr_data[LR_W-1:0];
               end
               CSR_FIRST_MOMENT_SCALE: begin
                  ms1_reg <= csr_wr_data[MS1_W-1:0];
               end
               CSR_SECOND_MOMENT_SCALE: begin
                  ms2_reg <= csr_wr_data[MS2_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

@@ test/tb_adam_weight_update.sv @@
`timescale 1ns / 1ps
module tb_adam_weight_update;
   import awu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    error_count;
   int                    weights_pending;
   int                    cycle_count;
   bit                    gaps_on;

   adam_weight_update dut (.*);

   awu_scoreboard checker_inst (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= gaps_on ? ($urandom_range(99) < 34) : 1'b0;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_update(input logic [IDX_W-1:0] idx, input logic [31:0] g,
                              input logic [31:0] w);
      while (gaps_on && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{element_index: idx, grad_value: g, weight_value: w};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (weights_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [31:0] random_grad;
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return 32'($signed($urandom_range(33554432)) - 16777216);
      if (sel < 7) return 32'($signed($urandom_range(1048576)) - 524288);
      return $urandom;
   endfunction

   function automatic logic [31:0] random_weight;
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return W_MAX - $urandom_range(65536);
      if (sel == 1) return W_MIN + $urandom_range(65536);
      if (sel < 6) return 32'($signed($urandom_range(67108864)) - 33554432);
      return $urandom;
   endfunction

   task automatic random_phase(input int n);
      logic [IDX_W-1:0] idx;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 7) idx = IDX_W'($urandom_range(15));
         else idx = IDX_W'($urandom);
         send_update(idx, random_grad(), random_weight());
      end
   endtask

   initial begin
      cycle_count = 0;
      gaps_on = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_LEARNING_RATE;
      csr_wr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_update(12'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_update(12'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_update(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000);
      send_update(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000);
      send_update(12'd1, 32'd0, 32'd0);
      send_update(12'd2, 32'hFFFF_FFFF, 32'h0100_0000);
      send_update(12'd3, 32'd1, 32'hFF00_0000);
      send_update(12'd4, 32'h0100_0000, 32'h7FFF_FFFF);
      send_update(12'd5, 32'hFF00_0000, 32'h8000_0000);
      send_update(12'd2730, 32'h5555_5555, 32'hAAAA_AAAA);
      send_update(12'd1365, 32'hAAAA_AAAA, 32'h5555_5555);
      drain();

      gaps_on = 1'b1;
      random_phase(250);
      drain();

      write_csr(CSR_LEARNING_RATE, 26'd16777216);
      write_csr(CSR_FIRST_MOMENT_SCALE, 26'd65536);
      write_csr(CSR_SECOND_MOMENT_SCALE, 26'd65536);
      gaps_on = 1'b0;
      random_phase(250);
      drain();

      write_csr(CSR_LEARNING_RATE, 26'd0);
      write_csr(CSR_FIRST_MOMENT_SCALE, 26'd655360);
      write_csr(CSR_SECOND_MOMENT_SCALE, 26'd65536000);
      gaps_on = 1'b1;
      random_phase(150);
      drain();

      write_csr(CSR_LEARNING_RATE, 26'h3FF_FFFF);
      write_csr(CSR_FIRST_MOMENT_SCALE, 26'h3FF_FFFF);
      write_csr(CSR_SECOND_MOMENT_SCALE, 26'd0);
      write_csr(CSR_UNMAPPED, 26'h2AA_AAAA);
      random_phase(150);
      drain();

      write_csr(CSR_LEARNING_RATE, 26'h3FF_FFFF);
      write_csr(CSR_FIRST_MOMENT_SCALE, 26'd65536);
      write_csr(CSR_SECOND_MOMENT_SCALE, 26'h3FF_FFFF);
      random_phase(150);
      drain();

      write_csr(CSR_LEARNING_RATE, CSR_DATA_W'($urandom_range(16777216)));
      write_csr(CSR_FIRST_MOMENT_SCALE, CSR_DATA_W'($urandom_range(655360, 65536)));
      write_csr(CSR_SECOND_MOMENT_SCALE, CSR_DATA_W'($urandom_range(65536000, 65536)));
      random_phase(340);
      drain();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
